@@ hw/rtl/stc_pkg.sv @@
package stc_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int INDEX_BITS_DEF  = 8;

  localparam int FUNC_W   = 2;
  localparam int COORD_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACCUM  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EMIT   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVF   = 2'd2;

  typedef struct packed {
    logic load_item;
    logic search;
    logic rd_hit;
    logic rd_scan;
    logic scan_clr;
    logic store_new;
    logic store_sum;
    logic pend_load;
    logic out_pend;
    logic out_last;
    logic out_empty;
    logic out_ovf;
    logic table_clr;
  } stc_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] in_func;
    logic              in_zero;
    logic              hit;
    logic              full;
    logic              scan_done;
    logic              rd_zero;
    logic              pend_valid;
    logic              out_free;
  } stc_status_t;

endpackage

@@ hw/rtl/stc_datapath.sv @@
module stc_datapath #(
  parameter int TABLE_DEPTH = stc_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = stc_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stc_pkg::stc_cmd_t                   cmd,
  output stc_pkg::stc_status_t                st,
  input  logic [stc_pkg::FUNC_W-1:0]          in_func,
  input  logic [stc_pkg::COORD_W-1:0]         in_row_index,
  input  logic [stc_pkg::COORD_W-1:0]         in_col_index,
  input  logic signed [stc_pkg::VALUE_W-1:0]  in_entry_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stc_pkg::COORD_W-1:0]         out_row,
  output logic [stc_pkg::COORD_W-1:0]         out_col,
  output logic signed [stc_pkg::VALUE_W-1:0]  out_value,
  output logic                                out_last,
  output logic [stc_pkg::STATUS_W-1:0]        out_status
);

  localparam int AddrBits  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FillBits  = $clog2(TABLE_DEPTH + 1);
  localparam int KeyBits   = (INDEX_BITS < stc_pkg::COORD_W) ? INDEX_BITS : stc_pkg::COORD_W;
  localparam int ValBits   = stc_pkg::VALUE_W;
  localparam int EntryBits = 2 * KeyBits + ValBits;

  logic [KeyBits-1:0]   item_row_r;
  logic [KeyBits-1:0]   item_col_r;
  logic [ValBits-1:0]   item_val_r;

  logic [KeyBits-1:0]   key_row_r [TABLE_DEPTH];
  logic [KeyBits-1:0]   key_col_r [TABLE_DEPTH];
  logic [EntryBits-1:0] tbl_mem_r [TABLE_DEPTH];
  logic [EntryBits-1:0] rd_data_r;

  logic [FillBits-1:0]  fill_r;
  logic [FillBits-1:0]  fill_nxt;
  logic [FillBits-1:0]  scan_r;
  logic [FillBits-1:0]  scan_nxt;
  logic [TABLE_DEPTH-1:0] match_r;
  logic [TABLE_DEPTH-1:0] match_nxt;
  logic [AddrBits-1:0]  hit_idx;
  logic [AddrBits-1:0]  hit_idx_r;

  logic [EntryBits-1:0] pend_r;
  logic                 pend_valid_r;
  logic                 pend_valid_nxt;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [KeyBits-1:0]   out_row_r;
  logic [KeyBits-1:0]   out_col_r;
  logic [ValBits-1:0]   out_value_r;
  logic                 out_last_r;
  logic [stc_pkg::STATUS_W-1:0] out_status_r;

  logic                 mem_we;
  logic [AddrBits-1:0]  mem_waddr;
  logic [EntryBits-1:0] mem_wdata;
  logic                 mem_re;
  logic [AddrBits-1:0]  mem_raddr;
  logic [ValBits-1:0]   sum;
  logic                 out_load;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_row_r <= in_row_index[KeyBits-1:0];
      item_col_r <= in_col_index[KeyBits-1:0];
      item_val_r <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_new) begin
      key_row_r[fill_r[AddrBits-1:0]] <= item_row_r;
      key_col_r[fill_r[AddrBits-1:0]] <= item_col_r;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_match
    assign match_nxt[i] = (FillBits'(i) < fill_r) && (key_row_r[i] == item_row_r) &&
                          (key_col_r[i] == item_col_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      match_r <= match_nxt;
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = AddrBits'(i);
      end
    end
  end

  assign sum       = rd_data_r[ValBits-1:0] + item_val_r;
  assign mem_we    = cmd.store_new | cmd.store_sum;
  assign mem_waddr = cmd.store_sum ? hit_idx_r : fill_r[AddrBits-1:0];
  assign mem_wdata = cmd.store_sum ? {item_row_r, item_col_r, sum}
                                   : {item_row_r, item_col_r, item_val_r};
  assign mem_re    = cmd.rd_hit | cmd.rd_scan;
  assign mem_raddr = cmd.rd_hit ? hit_idx : scan_r[AddrBits-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= tbl_mem_r[mem_raddr];
    end
    if (cmd.rd_hit) begin
      hit_idx_r <= hit_idx;
    end
    if (cmd.pend_load) begin
      pend_r <= rd_data_r;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.table_clr) begin
      fill_nxt = '0;
    end else if (cmd.store_new) begin
      fill_nxt = fill_r + FillBits'(1);
    end
    scan_nxt = scan_r;
    if (cmd.scan_clr) begin
      scan_nxt = '0;
    end else if (cmd.rd_scan) begin
      scan_nxt = scan_r + FillBits'(1);
    end
    pend_valid_nxt = pend_valid_r;
    if (cmd.scan_clr || cmd.table_clr) begin
      pend_valid_nxt = 1'b0;
    end else if (cmd.pend_load) begin
      pend_valid_nxt = 1'b1;
    end
  end

  assign out_load = cmd.out_pend | cmd.out_empty | cmd.out_ovf;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      scan_r       <= scan_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_pend) begin
      out_row_r    <= pend_r[EntryBits-1 -: KeyBits];
      out_col_r    <= pend_r[ValBits +: KeyBits];
      out_value_r  <= pend_r[ValBits-1:0];
      out_last_r   <= cmd.out_last;
      out_status_r <= stc_pkg::STATUS_VALID;
    end else if (cmd.out_ovf) begin
      out_row_r    <= item_row_r;
      out_col_r    <= item_col_r;
      out_value_r  <= item_val_r;
      out_last_r   <= 1'b1;
      out_status_r <= stc_pkg::STATUS_OVF;
    end else if (cmd.out_empty) begin
      out_row_r    <= '0;
      out_col_r    <= '0;
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= stc_pkg::STATUS_EMPTY;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = stc_pkg::COORD_W'(out_row_r);
  assign out_col    = stc_pkg::COORD_W'(out_col_r);
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  assign st.in_func    = in_func;
  assign st.in_zero    = (in_entry_value == '0);
  assign st.hit        = |match_r;
  assign st.full       = (fill_r == FillBits'(TABLE_DEPTH));
  assign st.scan_done  = (scan_r == fill_r);
  assign st.rd_zero    = (rd_data_r[ValBits-1:0] == '0);
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = !out_valid_r || out_ready;

endmodule

@@ hw/rtl/stc_controller.sv @@
module stc_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stc_pkg::stc_status_t st,
  output stc_pkg::stc_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_APPEND   = 9'b000000010,
    S_SEARCH   = 9'b000000100,
    S_DECIDE   = 9'b000001000,
    S_ADD      = 9'b000010000,
    S_OVF      = 9'b000100000,
    S_EMIT_RD  = 9'b001000000,
    S_EMIT_CHK = 9'b010000000,
    S_EMIT_END = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (st.in_func)
            stc_pkg::FUNC_APPEND: begin
              if (!st.in_zero) begin
                state_nxt = S_APPEND;
              end
            end
            stc_pkg::FUNC_ACCUM: begin
              if (!st.in_zero) begin
                state_nxt = S_SEARCH;
              end
            end
            stc_pkg::FUNC_EMIT: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_EMIT_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_APPEND: begin
        if (st.full) begin
          state_nxt = S_OVF;
        end else begin
          cmd.store_new = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.hit) begin
          cmd.rd_hit = 1'b1;
          state_nxt  = S_ADD;
        end else if (st.full) begin
          state_nxt = S_OVF;
        end else begin
          cmd.store_new = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ADD: begin
        cmd.store_sum = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_OVF: begin
        if (st.out_free) begin
          cmd.out_ovf = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        if (st.scan_done) begin
          state_nxt = S_EMIT_END;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_EMIT_CHK;
        end
      end
      S_EMIT_CHK: begin
        if (st.rd_zero) begin
          state_nxt = S_EMIT_RD;
        end else if (!st.pend_valid) begin
          cmd.pend_load = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else if (st.out_free) begin
          cmd.out_pend  = 1'b1;
          cmd.pend_load = 1'b1;
          state_nxt     = S_EMIT_RD;
        end
      end
      S_EMIT_END: begin
        if (st.out_free) begin
          if (st.pend_valid) begin
            cmd.out_pend = 1'b1;
            cmd.out_last = 1'b1;
          end else begin
            cmd.out_empty = 1'b1;
          end
          cmd.table_clr = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/sparse_triplet_accumulator.sv @@
// Sparse matrix adder on (row, column, value) triplets held in an internal table.
// Input channel (in_valid/in_ready) carries one command per transaction: append a
// first-matrix entry, accumulate a second-matrix entry, or emit the sum.
// Output channel (out_valid/out_ready) carries result entries, one per transaction.
// An append is accepted and then stored. An accumulate is accepted, then one step
// registers the parallel coordinate compare against all stored entries. On an insert
// the next step stores the entry; on a match it picks the first match and reads its
// value, and one more step adds and writes the sum back into the value memory.
// An emit reads the value memory one entry at a time and holds one result back
// so that the final one can carry out_last; the table empties at its end.
// Zero-valued entries and unused commands finish with no result.
// A result waits in the output register while the receiver stalls; the block keeps
// taking commands that produce no result, and stalls an emit or an overflow result
// until the register frees. Reset empties the table and the output register; it
// needs no clearing pass.
module sparse_triplet_accumulator #(
  parameter int TABLE_DEPTH = stc_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = stc_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [stc_pkg::FUNC_W-1:0]          in_func,
  input  logic [stc_pkg::COORD_W-1:0]         in_row_index,
  input  logic [stc_pkg::COORD_W-1:0]         in_col_index,
  input  logic signed [stc_pkg::VALUE_W-1:0]  in_entry_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stc_pkg::COORD_W-1:0]         out_row,
  output logic [stc_pkg::COORD_W-1:0]         out_col,
  output logic signed [stc_pkg::VALUE_W-1:0]  out_value,
  output logic                                out_last,
  output logic [stc_pkg::STATUS_W-1:0]        out_status
);

  stc_pkg::stc_cmd_t    cmd;
  stc_pkg::stc_status_t st;

  stc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  stc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_func        (in_func),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule

@@ hw/rtl/stc_checker.sv @@
module stc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [stc_pkg::COORD_W-1:0]         out_row,
  input logic [stc_pkg::COORD_W-1:0]         out_col,
  input logic signed [stc_pkg::VALUE_W-1:0]  out_value,
  input logic                                out_last,
  input logic [stc_pkg::STATUS_W-1:0]        out_status
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row) &&
                                $stable(out_col) && $stable(out_last) && $stable(out_status))
    else $error("stalled result changed");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == stc_pkg::STATUS_EMPTY |->
      out_last && out_value == '0 && out_row == '0 && out_col == '0)
    else $error("empty result malformed");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == stc_pkg::STATUS_OVF |-> out_last)
    else $error("overflow result not marked last");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == stc_pkg::STATUS_VALID |-> out_value != '0)
    else $error("emitted entry has zero value");

endmodule

bind sparse_triplet_accumulator stc_checker u_stc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_row    (out_row),
  .out_col    (out_col),
  .out_value  (out_value),
  .out_last   (out_last),
  .out_status (out_status)
);

@@ verif/sparse_triplet_accumulator_checker.sv @@
module sparse_triplet_accumulator_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [stc_pkg::FUNC_W-1:0]         in_func,
  input  logic [stc_pkg::COORD_W-1:0]        in_row_index,
  input  logic [stc_pkg::COORD_W-1:0]        in_col_index,
  input  logic signed [stc_pkg::VALUE_W-1:0] in_entry_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [stc_pkg::COORD_W-1:0]        out_row,
  input  logic [stc_pkg::COORD_W-1:0]        out_col,
  input  logic signed [stc_pkg::VALUE_W-1:0] out_value,
  input  logic                               out_last,
  input  logic [stc_pkg::STATUS_W-1:0]       out_status,
  output int                                 mismatch_count,
  output int                                 pending_count,
  output int                                 result_count,
  output int                                 match_count,
  output int                                 overflow_count,
  output int                                 empty_count
);

  localparam int REPORT_LIMIT = 10;
  localparam int DEPTH        = stc_pkg::TABLE_DEPTH_DEF;
  localparam int FUNC_W       = stc_pkg::FUNC_W;
  localparam int COORD_W      = stc_pkg::COORD_W;
  localparam int VALUE_W      = stc_pkg::VALUE_W;
  localparam int STATUS_W     = stc_pkg::STATUS_W;

  typedef struct {
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [VALUE_W-1:0]  value;
    logic                last;
    logic [STATUS_W-1:0] status;
  } sum_entry_t;

  logic [COORD_W-1:0] sum_row [DEPTH];
  logic [COORD_W-1:0] sum_col [DEPTH];
  logic [VALUE_W-1:0] sum_val [DEPTH];
  int                 sum_fill = 0;
  sum_entry_t         due_sums[$];

  int n_bad     = 0;
  int n_results = 0;
  int n_hits    = 0;
  int n_ovf     = 0;
  int n_empty   = 0;

  function automatic void queue_sum(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                                    input logic [VALUE_W-1:0] v, input logic is_last,
                                    input logic [STATUS_W-1:0] st);
    sum_entry_t e;
    e.row    = r;
    e.col    = c;
    e.value  = v;
    e.last   = is_last;
    e.status = st;
    due_sums.push_back(e);
  endfunction

  function automatic void predict_sums(input logic [FUNC_W-1:0] f,
                                       input logic [COORD_W-1:0] r,
                                       input logic [COORD_W-1:0] c,
                                       input logic [VALUE_W-1:0] v);
    int hit;
    int nonzero;
    int k;
    int i;
    if (f == stc_pkg::FUNC_APPEND || f == stc_pkg::FUNC_ACCUM) begin
      if (v == '0) return;
      hit = -1;
      if (f == stc_pkg::FUNC_ACCUM) begin
        for (i = 0; i < sum_fill; i++) begin
          if (hit < 0 && sum_row[i] == r && sum_col[i] == c) hit = i;
        end
      end
      if (hit >= 0) begin
        sum_val[hit] = sum_val[hit] + v;
        n_hits++;
      end else if (sum_fill >= DEPTH) begin
        queue_sum(r, c, v, 1'b1, stc_pkg::STATUS_OVF);
        n_ovf++;
      end else begin
        sum_row[sum_fill] = r;
        sum_col[sum_fill] = c;
        sum_val[sum_fill] = v;
        sum_fill++;
      end
    end else if (f == stc_pkg::FUNC_EMIT) begin
      nonzero = 0;
      for (i = 0; i < sum_fill; i++) begin
        if (sum_val[i] != '0) nonzero++;
      end
      k = 0;
      for (i = 0; i < sum_fill; i++) begin
        if (sum_val[i] != '0) begin
          k++;
          queue_sum(sum_row[i], sum_col[i], sum_val[i], k == nonzero, stc_pkg::STATUS_VALID);
        end
      end
      if (nonzero == 0) begin
        queue_sum('0, '0, '0, 1'b1, stc_pkg::STATUS_EMPTY);
        n_empty++;
      end
      sum_fill = 0;
    end
  endfunction

  always @(posedge clk) begin
    sum_entry_t e;
    if (!rst_n) begin
      sum_fill = 0;
      due_sums.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (due_sums.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_LIMIT)
            $display("unexpected result transaction: row %0d col %0d value %0d",
                     out_row, out_col, out_value, " last %0d status %0d",
                     out_last, out_status);
        end else begin
          e = due_sums.pop_front();
          if (out_row !== e.row || out_col !== e.col || out_value !== e.value ||
              out_last !== e.last || out_status !== e.status) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT) begin
              $display("mismatch: expected row %0d col %0d value %0d last %0d status %0d",
                       e.row, e.col, $signed(e.value), e.last, e.status);
              $display("          actual   row %0d col %0d value %0d last %0d status %0d",
                       out_row, out_col, out_value, out_last, out_status);
            end
          end
        end
      end
      if (in_valid && in_ready)
        predict_sums(in_func, in_row_index, in_col_index, in_entry_value);
    end
    mismatch_count <= n_bad;
    pending_count  <= due_sums.size();
    result_count   <= n_results;
    match_count    <= n_hits;
    overflow_count <= n_ovf;
    empty_count    <= n_empty;
  end

endmodule

@@ verif/sparse_triplet_accumulator_test.sv @@
module sparse_triplet_accumulator_test;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int RANDOM_COMMANDS = 350;
  localparam int PHASE_COMMANDS  = 45;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 300000;

  localparam int DEPTH    = stc_pkg::TABLE_DEPTH_DEF;
  localparam int FUNC_W   = stc_pkg::FUNC_W;
  localparam int COORD_W  = stc_pkg::COORD_W;
  localparam int VALUE_W  = stc_pkg::VALUE_W;
  localparam int STATUS_W = stc_pkg::STATUS_W;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic [FUNC_W-1:0]         in_func        = stc_pkg::FUNC_APPEND;
  logic [COORD_W-1:0]        in_row_index   = '0;
  logic [COORD_W-1:0]        in_col_index   = '0;
  logic signed [VALUE_W-1:0] in_entry_value = '0;
  logic                      out_ready      = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic [COORD_W-1:0]        out_row;
  logic [COORD_W-1:0]        out_col;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;
  logic [STATUS_W-1:0]       out_status;

  int mismatch_count;
  int pending_count;
  int result_count;
  int match_count;
  int overflow_count;
  int empty_count;

  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int commands_sent = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  sparse_triplet_accumulator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  sparse_triplet_accumulator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_last       (out_last),
    .out_status     (out_status),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .match_count    (match_count),
    .overflow_count (overflow_count),
    .empty_count    (empty_count)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sparse_triplet_accumulator test failed");
      $finish;
    end
  end

  // The long hold-off lets the block fill its output register and stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic void set_traffic(input int phase);
    case (phase)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 74;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 74;
      end
      default: begin
        send_idle_pct = 13;
        stall_pct     = 13;
      end
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int s;
    s = $urandom_range(6);
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3, 4, 5: return VALUE_W'(s - 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [COORD_W-1:0] r,
                          input logic [COORD_W-1:0] c, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_row_index   <= r;
    in_col_index   <= c;
    in_entry_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
  endtask

  task automatic run_batch(input bit fill_up);
    logic [COORD_W-1:0] pool_row [4];
    logic [COORD_W-1:0] pool_col [4];
    int                 n_cmds;
    int                 stored;
    int                 sel;
    int                 p;
    logic [FUNC_W-1:0]  f;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [VALUE_W-1:0] v;
    foreach (pool_row[i]) begin
      pool_row[i] = COORD_W'($urandom_range(255));
      pool_col[i] = COORD_W'($urandom_range(255));
    end
    n_cmds = $urandom_range(14);
    stored = 0;
    while (fill_up ? (stored < DEPTH + 3) : (n_cmds > 0)) begin
      sel = $urandom_range(99);
      p   = $urandom_range(3);
      v   = pick_value();
      if (fill_up) begin
        if (sel < 75) begin
          f = stc_pkg::FUNC_APPEND;
          r = COORD_W'($urandom_range(255));
          c = COORD_W'($urandom_range(255));
          if (v != '0) stored++;
        end else begin
          f = stc_pkg::FUNC_ACCUM;
          r = pool_row[p];
          c = pool_col[p];
        end
      end else begin
        f = (sel < 4) ? FUNC_UNUSED :
            (sel < 45) ? stc_pkg::FUNC_APPEND : stc_pkg::FUNC_ACCUM;
        if ($urandom_range(99) < 75) begin
          r = pool_row[p];
          c = pool_col[p];
        end else begin
          r = COORD_W'($urandom_range(255));
          c = COORD_W'($urandom_range(255));
        end
        n_cmds--;
      end
      send_cmd(f, r, c, v);
    end
    send_cmd(stc_pkg::FUNC_EMIT, COORD_W'($urandom_range(255)),
             COORD_W'($urandom_range(255)), VALUE_W'($urandom));
  endtask

  initial begin
    int base;
    int batch_no;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_traffic(0);
    send_cmd(stc_pkg::FUNC_EMIT, 8'd0, 8'd0, 32'd0);
    send_cmd(stc_pkg::FUNC_APPEND, 8'd0, 8'd0, 32'd1);
    send_cmd(stc_pkg::FUNC_APPEND, 8'd255, 8'd255, 32'h8000_0000);
    send_cmd(stc_pkg::FUNC_APPEND, 8'd170, 8'd85, 32'h7fff_ffff);
    send_cmd(stc_pkg::FUNC_APPEND, 8'd3, 8'd4, 32'd0);
    send_cmd(stc_pkg::FUNC_ACCUM, 8'd170, 8'd85, 32'd1);
    send_cmd(stc_pkg::FUNC_ACCUM, 8'd0, 8'd0, 32'hffff_ffff);
    send_cmd(stc_pkg::FUNC_ACCUM, 8'd85, 8'd170, 32'd5);
    send_cmd(stc_pkg::FUNC_ACCUM, 8'd85, 8'd170, 32'd0);
    send_cmd(FUNC_UNUSED, 8'd255, 8'd255, 32'hffff_ffff);
    send_cmd(stc_pkg::FUNC_APPEND, 8'd255, 8'd255, 32'd7);
    send_cmd(stc_pkg::FUNC_ACCUM, 8'd255, 8'd255, 32'd3);
    send_cmd(stc_pkg::FUNC_EMIT, 8'd255, 8'd255, 32'hffff_ffff);
    send_cmd(stc_pkg::FUNC_APPEND, 8'd1, 8'd1, 32'd4);
    send_cmd(stc_pkg::FUNC_ACCUM, 8'd1, 8'd1, 32'hffff_fffc);
    send_cmd(stc_pkg::FUNC_EMIT, 8'd0, 8'd0, 32'd0);

    base     = commands_sent;
    batch_no = 0;
    while (commands_sent - base < RANDOM_COMMANDS) begin
      set_traffic(((commands_sent - base) / PHASE_COMMANDS) % 4);
      if (batch_no == 2) hold_req = 1'b1;
      run_batch(batch_no % 6 == 1);
      batch_no++;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d result transactions under four traffic modes,",
             commands_sent, result_count);
    $display("with %0d accumulate matches, %0d full-table refusals and %0d empty emits.",
             match_count, overflow_count, empty_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("sparse_triplet_accumulator test passed");
    end else begin
      $display("sparse_triplet_accumulator test failed");
    end
    $finish;
  end

endmodule
